// ===== hw/rtl/jslsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint slew limiter package
// Shared widths, register indexes, scale constants and stage control type.
// ----------------------------------------------------------------------------
package jslsp_pkg;

  localparam int JOINTS          = 5;
  localparam int ANGLE_W         = 16;
  localparam int ANGLE_FRAC_BITS = 12;
  localparam int POS_W           = 10;
  localparam int VEL_IN_W        = 32;
  localparam int VEL_W           = 11;
  localparam int DELTA_W         = 12;
  localparam int VLIM_W          = 10;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 12;
  localparam int S_TDATA_W       = 112;
  localparam int S_TUSER_W       = 2;
  localparam int M_TDATA_W       = 64;

  localparam logic [POS_W-1:0] POS_MAX = 10'd1023;

  // Magnitude of a (possibly negated) angle; -(-32768) still fits unsigned.
  localparam int MAG_W = ANGLE_W;

  // 512/pi as unsigned Q32, split into two 20-bit halves so each partial
  // product stays a small multiplier: SCALE = SCALE_HI * 2^20 + SCALE_LO.
  localparam int              SCALE_SPLIT = 20;
  localparam logic [19:0]     SCALE_HI    = 20'd667544;
  localparam logic [19:0]     SCALE_LO    = 20'd224846;
  localparam int              PP_W        = MAG_W + SCALE_SPLIT;
  localparam int              PROD_W      = PP_W + SCALE_SPLIT + 1;
  localparam int              ROUND_SHIFT = 32 + ANGLE_FRAC_BITS;
  localparam int              OFF_W       = PROD_W - ROUND_SHIFT;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (ROUND_SHIFT - 1);

  // Signed width wide enough for center +/- offset.
  localparam int SUM_W = OFF_W + 2;

  typedef logic signed [ANGLE_W-1:0] angle_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STEP_LIMIT   = 3'd0,
    REG_MAX_VELOCITY = 3'd1,
    REG_SIGN_MASK    = 3'd2,
    REG_CENTER_0     = 3'd3,
    REG_CENTER_1     = 3'd4,
    REG_CENTER_2     = 3'd5,
    REG_CENTER_3     = 3'd6,
    REG_CENTER_4     = 3'd7
  } cfg_reg_t;

  // Per-stage advance strobes, driven by the top-level flow control.
  typedef struct packed {
    logic adv1;
    logic adv2;
    logic adv3;
  } stage_en_t;

endpackage

// ===== hw/rtl/joint_slew_limit_servo_position_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Joint slew limiter with servo position mapping
// Five joint lanes move held angles toward their targets by a bounded step
// and map them to ten-bit servo positions; a velocity command is saturated.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Fields (lowest bit first)
// s_t*      in         tdata: target_0..target_4, velocity_request
//                      tuser: targets_complete, velocity_present
// m_t*      out        tdata: servo_pos_0..servo_pos_4, velocity_out
// cfg_*     in         cfg_we, cfg_index, cfg_data (no read-back)
//
// The block takes one request per clock unless a result-side stall has
// backed up to the input. A request passes four register stages: input,
// slew update, partial products, result. The slew update of the held angles
// is the only loop, which sets the rate. A request without targets_complete
// is dropped at the input stage and leaves no trace. Each stage moves
// whenever the one after it is free or draining, so a stall on the result
// side backs up through the stages before the input side is held off.
// Reset clears the held angles, the primed flag, all valid flags and the
// configuration registers to their defaults.
//
module joint_slew_limit_servo_position_core (
  input  logic                                 clk,
  input  logic                                 rst,
  // Input requests.
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [79:0] target_0..target_4 (16 each), [111:80] velocity_request
  input  logic [jslsp_pkg::S_TDATA_W-1:0]      s_tdata,
  // [0] targets_complete, [1] velocity_present
  input  logic [jslsp_pkg::S_TUSER_W-1:0]      s_tuser,
  // Results.
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [49:0] servo_pos_0..servo_pos_4 (10 each), [60:50] velocity_out, rest 0
  output logic [jslsp_pkg::M_TDATA_W-1:0]      m_tdata,
  // Configuration writes.
  input  logic                                 cfg_we,
  input  logic [jslsp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [jslsp_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import jslsp_pkg::*;

  // Configuration registers.
  logic [DELTA_W-1:0] step_limit;
  logic [VLIM_W-1:0]  max_velocity;
  logic [JOINTS-1:0]  sign_mask;
  logic [POS_W-1:0]   center [JOINTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      step_limit   <= DELTA_W'(61);
      max_velocity <= VLIM_W'(200);
      sign_mask    <= '0;
      for (int j = 0; j < JOINTS; j++) begin
        center[j] <= POS_W'(512);
      end
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_STEP_LIMIT:   step_limit   <= cfg_data[DELTA_W-1:0];
        REG_MAX_VELOCITY: max_velocity <= cfg_data[VLIM_W-1:0];
        REG_SIGN_MASK:    sign_mask    <= cfg_data[JOINTS-1:0];
        REG_CENTER_0:     center[0]    <= cfg_data[POS_W-1:0];
        REG_CENTER_1:     center[1]    <= cfg_data[POS_W-1:0];
        REG_CENTER_2:     center[2]    <= cfg_data[POS_W-1:0];
        REG_CENTER_3:     center[3]    <= cfg_data[POS_W-1:0];
        REG_CENTER_4:     center[4]    <= cfg_data[POS_W-1:0];
        default: ;
      endcase
    end
  end

  // Stage valid flags and flow control. A stage is ready when it is empty
  // or when its content moves on in the same cycle.
  logic      v0, v1, v2, v3;
  logic      rdy1, rdy2, rdy3;
  logic      primed;
  stage_en_t en;

  assign rdy3     = !v3 || m_tready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = !v0 || rdy1;
  assign en.adv1  = v0 && rdy1;
  assign en.adv2  = v1 && rdy2;
  assign en.adv3  = v2 && rdy3;
  assign m_tvalid = v3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0     <= 1'b0;
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      primed <= 1'b0;
    end else begin
      if (s_tready) begin
        // Incomplete requests never enter the pipeline.
        v0 <= s_tvalid && s_tuser[0];
      end
      if (rdy1) begin
        v1 <= v0;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (en.adv1) begin
        primed <= 1'b1;
      end
    end
  end

  // Input stage payload.
  angle_t                     tgt [JOINTS];
  logic                       vel_present;
  logic signed [VEL_IN_W-1:0] vel_request;

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      for (int j = 0; j < JOINTS; j++) begin
        tgt[j] <= s_tdata[j*ANGLE_W +: ANGLE_W];
      end
      vel_present <= s_tuser[1];
      vel_request <= s_tdata[JOINTS*ANGLE_W +: VEL_IN_W];
    end
  end

  // Joint lanes: slew update, then position mapping.
  logic [POS_W-1:0] pos [JOINTS];

  for (genvar j = 0; j < JOINTS; j++) begin : g_lane
    logic             neg;
    logic [MAG_W-1:0] mag;

    jslsp_slew_lane u_slew (
      .clk        (clk),
      .rst        (rst),
      .en         (en),
      .primed     (primed),
      .target     (tgt[j]),
      .step_limit (step_limit),
      .invert     (sign_mask[j]),
      .neg        (neg),
      .mag        (mag)
    );

    jslsp_pos_map u_map (
      .clk    (clk),
      .en     (en),
      .neg    (neg),
      .mag    (mag),
      .center (center[j]),
      .pos    (pos[j])
    );
  end

  // Velocity path: saturate at the slew stage, then ride along.
  logic signed [VEL_W-1:0] vel_sat;
  logic signed [VEL_W-1:0] vel1, vel2, vel3;

  jslsp_vel_sat u_vel (
    .present (vel_present),
    .request (vel_request),
    .limit   (max_velocity),
    .vel     (vel_sat)
  );

  always_ff @(posedge clk) begin
    if (en.adv1) begin
      vel1 <= vel_sat;
    end
    if (en.adv2) begin
      vel2 <= vel1;
    end
    if (en.adv3) begin
      vel3 <= vel2;
    end
  end

  // Result packing.
  always_comb begin
    m_tdata = '0;
    for (int j = 0; j < JOINTS; j++) begin
      m_tdata[j*POS_W +: POS_W] = pos[j];
    end
    m_tdata[JOINTS*POS_W +: VEL_W] = vel3;
  end

endmodule

// ===== hw/rtl/jslsp_slew_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Slew lane
// Holds one joint angle, loads it from the first target, then steps it toward
// the target; registers sign and magnitude of the direction-corrected result.
// ----------------------------------------------------------------------------
module jslsp_slew_lane (
  input  logic                            clk,
  input  logic                            rst,
  input  jslsp_pkg::stage_en_t            en,
  input  logic                            primed,
  input  jslsp_pkg::angle_t               target,
  input  logic [jslsp_pkg::DELTA_W-1:0]   step_limit,
  input  logic                            invert,
  output logic                            neg,
  output logic [jslsp_pkg::MAG_W-1:0]     mag
);
  import jslsp_pkg::*;

  angle_t                     held;
  angle_t                     held_next;
  angle_t                     step;
  logic signed [ANGLE_W:0]    diff;
  logic signed [ANGLE_W:0]    md;
  logic signed [ANGLE_W:0]    ang;
  logic signed [ANGLE_W:0]    ang_abs;

  always_comb begin
    diff = {target[ANGLE_W-1], target} - {held[ANGLE_W-1], held};
    md   = $signed({{(ANGLE_W + 1 - DELTA_W){1'b0}}, step_limit});
    // The new value lies between held and target, so 16 bits always suffice.
    if (diff > md) begin
      step = ANGLE_W'({held[ANGLE_W-1], held} + md);
    end else if (diff < -md) begin
      step = ANGLE_W'({held[ANGLE_W-1], held} - md);
    end else begin
      step = target;
    end
    held_next = primed ? step : target;
    ang       = invert ? -{held_next[ANGLE_W-1], held_next}
                       : {held_next[ANGLE_W-1], held_next};
    ang_abs   = ang[ANGLE_W] ? -ang : ang;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (en.adv1) begin
      held <= held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en.adv1) begin
      neg <= ang[ANGLE_W];
      mag <= ang_abs[MAG_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/jslsp_pos_map.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Position mapper
// Scales an angle magnitude to servo counts in two registered steps:
// partial products, then sum, round, add center and clamp.
// ----------------------------------------------------------------------------
module jslsp_pos_map (
  input  logic                          clk,
  input  jslsp_pkg::stage_en_t          en,
  input  logic                          neg,
  input  logic [jslsp_pkg::MAG_W-1:0]   mag,
  input  logic [jslsp_pkg::POS_W-1:0]   center,
  output logic [jslsp_pkg::POS_W-1:0]   pos
);
  import jslsp_pkg::*;

  logic [PP_W-1:0]          pp_hi;
  logic [PP_W-1:0]          pp_lo;
  logic                     neg2;
  logic [PROD_W-1:0]        prod;
  logic [OFF_W-1:0]         off;
  logic signed [SUM_W-1:0]  sum;
  logic [POS_W-1:0]         pos_next;

  always_ff @(posedge clk) begin
    if (en.adv2) begin
      pp_hi <= PP_W'(mag) * PP_W'(SCALE_HI);
      pp_lo <= PP_W'(mag) * PP_W'(SCALE_LO);
      neg2  <= neg;
    end
  end

  always_comb begin
    prod = (PROD_W'(pp_hi) << SCALE_SPLIT) + PROD_W'(pp_lo) + ROUND_HALF;
    off  = prod[ROUND_SHIFT +: OFF_W];
    if (neg2) begin
      sum = $signed(SUM_W'(center)) - $signed(SUM_W'(off));
    end else begin
      sum = $signed(SUM_W'(center)) + $signed(SUM_W'(off));
    end
    if (sum < 0) begin
      pos_next = '0;
    end else if (sum > $signed(SUM_W'(POS_MAX))) begin
      pos_next = POS_MAX;
    end else begin
      pos_next = sum[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en.adv3) begin
      pos <= pos_next;
    end
  end

endmodule

// ===== hw/rtl/jslsp_vel_sat.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Velocity saturator
// Zeroes a missing velocity and clamps it to a symmetric limit.
// ----------------------------------------------------------------------------
module jslsp_vel_sat (
  input  logic                                   present,
  input  logic signed [jslsp_pkg::VEL_IN_W-1:0]  request,
  input  logic [jslsp_pkg::VLIM_W-1:0]           limit,
  output logic signed [jslsp_pkg::VEL_W-1:0]     vel
);
  import jslsp_pkg::*;

  logic signed [VEL_IN_W-1:0] v;
  logic signed [VEL_IN_W-1:0] lim;

  always_comb begin
    v   = present ? request : '0;
    lim = $signed(VEL_IN_W'(limit));
    if (v > lim) begin
      vel = lim[VEL_W-1:0];
    end else if (v < -lim) begin
      vel = VEL_W'(-lim);
    end else begin
      vel = v[VEL_W-1:0];
    end
  end

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for joint_slew_limit_servo_position_core
// Drives joint target requests with random bursts and gaps. The result
// stream is stalled on a pattern of its own. A scoreboard keeps its own copy
// of the held angles and registers, predicts each servo command and checks
// every result field by field. The registers are reprogrammed between
// phases, with their extremes among the settings.
// ----------------------------------------------------------------------------
module testbench;
  import jslsp_pkg::*;

  // Five target angles, target_0 in the lowest bits, as they sit in s_tdata.
  typedef logic [JOINTS-1:0][ANGLE_W-1:0] aim_set_t;
  // One value per register, indexed by register number.
  typedef logic [7:0][CFG_DATA_W-1:0]     reg_image_t;

  typedef struct packed {
    logic signed [VEL_W-1:0]      vel;
    logic [JOINTS-1:0][POS_W-1:0] pos;
  } servo_cmd_t;

  // 512/pi in unsigned Q32: converts radians to servo counts.
  localparam longint unsigned RAD_TO_POS_Q32 = 64'd699970842190;
  localparam int              OFFSET_SHIFT   = 32 + ANGLE_FRAC_BITS;
  localparam longint unsigned OFFSET_HALF    = 64'd1 << (OFFSET_SHIFT - 1);
  localparam int              DRAIN_CYCLES   = 10;
  localparam int              WATCHDOG_LIMIT = 2000;
  localparam int              RANDOM_PHASES  = 8;
  localparam int              PHASE_REQUESTS = 100;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the held angles and registers, queues the expected
  // servo commands in request order and checks each result against them.
  // --------------------------------------------------------------------------
  class servo_scoreboard;
    logic [DELTA_W-1:0]        step_limit;
    logic [VLIM_W-1:0]         max_velocity;
    logic [JOINTS-1:0]         sign_mask;
    logic [POS_W-1:0]          center [JOINTS];
    logic signed [ANGLE_W-1:0] held [JOINTS];
    bit                        primed;
    servo_cmd_t                servo_cmd_q[$];
    int                        mismatches;
    int                        results_seen;
    int                        accepted;
    int                        dropped;

    function new();
      step_limit   = 12'd61;
      max_velocity = 10'd200;
      sign_mask    = '0;
      foreach (center[j]) begin
        center[j] = 10'd512;
        held[j]   = '0;
      end
      primed       = 1'b0;
      mismatches   = 0;
      results_seen = 0;
      accepted     = 0;
      dropped      = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_STEP_LIMIT:   step_limit   = val[DELTA_W-1:0];
        REG_MAX_VELOCITY: max_velocity = val[VLIM_W-1:0];
        REG_SIGN_MASK:    sign_mask    = val[JOINTS-1:0];
        default:          center[int'(idx) - int'(REG_CENTER_0)] = val[POS_W-1:0];
      endcase
    endfunction

    // Angle to servo count: optional negation in a wide word, scale by
    // 512/pi, round half away from zero, add the centre, clamp to 0..1023.
    function logic [POS_W-1:0] servo_position(int j, logic signed [ANGLE_W-1:0] ang);
      longint          a;
      longint unsigned mag;
      longint          pos;
      a = ang;
      if (sign_mask[j])
        a = -a;
      mag = longint'(a < 0 ? -a : a);
      mag = (mag * RAD_TO_POS_Q32 + OFFSET_HALF) >> OFFSET_SHIFT;
      if (a < 0)
        pos = longint'(center[j]) - longint'(mag);
      else
        pos = longint'(center[j]) + longint'(mag);
      if (pos < 0)
        pos = 0;
      else if (pos > longint'(POS_MAX))
        pos = longint'(POS_MAX);
      return pos[POS_W-1:0];
    endfunction

    // Called once per accepted request; incomplete requests are only counted.
    function void note_request(aim_set_t tgt, bit complete, bit vpres,
                               logic [VEL_IN_W-1:0] vreq);
      servo_cmd_t cmd;
      longint     step;
      longint     lim;
      longint     vel;
      longint     moved;
      int         j;
      accepted++;
      if (!complete) begin
        dropped++;
        return;
      end
      // The first complete request after reset takes the targets as they are.
      if (!primed) begin
        for (j = 0; j < JOINTS; j++)
          held[j] = signed'(tgt[j]);
        primed = 1'b1;
      end
      for (j = 0; j < JOINTS; j++) begin
        step = longint'(signed'(tgt[j])) - longint'(held[j]);
        if (step > longint'(step_limit))
          step = longint'(step_limit);
        else if (step < -longint'(step_limit))
          step = -longint'(step_limit);
        moved = longint'(held[j]) + step;
        held[j] = moved[ANGLE_W-1:0];
        cmd.pos[j] = servo_position(j, held[j]);
      end
      vel = vpres ? longint'(signed'(vreq)) : 0;
      lim = longint'(max_velocity);
      if (vel > lim)
        vel = lim;
      else if (vel < -lim)
        vel = -lim;
      cmd.vel = vel[VEL_W-1:0];
      servo_cmd_q.push_back(cmd);
    endfunction

    task report_mismatch(string what, longint got, longint want);
      $display("MISMATCH at result %0d, %s: got %0d, expected %0d",
               results_seen, what, got, want);
      mismatches++;
    endtask

    task check_servo_result(logic [M_TDATA_W-1:0] data);
      servo_cmd_t want;
      int         j;
      if (servo_cmd_q.size() == 0) begin
        report_mismatch("result with nothing outstanding", longint'(data), 0);
        return;
      end
      want = servo_cmd_q.pop_front();
      results_seen++;
      for (j = 0; j < JOINTS; j++)
        if (data[j*POS_W +: POS_W] !== want.pos[j])
          report_mismatch($sformatf("servo_pos_%0d", j),
                          longint'(data[j*POS_W +: POS_W]), longint'(want.pos[j]));
      if (data[JOINTS*POS_W +: VEL_W] !== want.vel)
        report_mismatch("velocity_out", longint'(signed'(data[JOINTS*POS_W +: VEL_W])),
                        longint'(want.vel));
      if (data[M_TDATA_W-1:JOINTS*POS_W+VEL_W] !== '0)
        report_mismatch("tdata padding", longint'(data[M_TDATA_W-1:JOINTS*POS_W+VEL_W]), 0);
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block itself. Every input starts at a known value.
  // --------------------------------------------------------------------------
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  logic [S_TDATA_W-1:0]  s_tdata   = '0;
  logic [S_TUSER_W-1:0]  s_tuser   = '0;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  cfg_we    = 1'b0;
  cfg_reg_t              cfg_index = REG_STEP_LIMIT;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  servo_scoreboard board = new();

  // Pacing knobs. The sender runs in bursts; gap_pct is the chance of an
  // idle gap before a new burst and stall_pct the chance that the result
  // side holds tready low for a while. Both are set per phase.
  int gap_pct     = 30;
  int stall_pct   = 30;
  int burst_left  = 0;
  int stall_hold  = 0;
  int idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  joint_slew_limit_servo_position_core DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // --------------------------------------------------------------------------
  // Result side: every accepted result goes to the scoreboard. Outputs are
  // read at the edge itself, before any of that edge's updates land, so the
  // values seen are the ones the handshake actually used. tready alternates
  // between ready stretches and stalls of random length.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      board.check_servo_result(m_tdata);
    if (stall_hold != 0) begin
      stall_hold <= stall_hold - 1;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      m_tready   <= 1'b0;
      stall_hold <= $urandom_range(0, 7);
    end else begin
      m_tready   <= 1'b1;
      stall_hold <= $urandom_range(0, 15);
    end
  end

  // Watchdog: any handshake or register write counts as progress. A run that
  // goes quiet for too long is declared failed.
  always @(posedge clk) begin
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired: nothing moved for %0d cycles.", WATCHDOG_LIMIT);
      $display("FAIL joint_slew_limit_servo_position_core");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic aim_set_t aims(int t0, int t1, int t2, int t3, int t4);
    return {16'(t4), 16'(t3), 16'(t2), 16'(t1), 16'(t0)};
  endfunction

  function automatic reg_image_t settings(int md, int mv, int sm,
                                          int c0, int c1, int c2, int c3, int c4);
    return {12'(c4), 12'(c3), 12'(c2), 12'(c1), 12'(c0), 12'(sm), 12'(mv), 12'(md)};
  endfunction

  // Mostly small moves around the previous target, so that the held angles
  // track and settle; now and then a full-range jump or an extreme angle.
  function automatic logic [ANGLE_W-1:0] next_aim(logic [ANGLE_W-1:0] prev);
    case ($urandom_range(0, 9))
      0:       return 16'($urandom());
      1:       return $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;
      default: return prev + 16'($urandom_range(0, 600)) - 16'd300;
    endcase
  endfunction

  // Mostly around the saturation limits, some full-range and extreme values.
  function automatic logic [VEL_IN_W-1:0] random_velocity();
    case ($urandom_range(0, 9))
      0, 1, 2: return $urandom();
      3:       return 32'h8000_0000;
      4:       return 32'h7FFF_FFFF;
      default: return 32'($urandom_range(0, 2400)) - 32'd1200;
    endcase
  endfunction

  // Random register image for one phase. The phase number rotates the slew
  // limit through small, full-range, medium and maximum steps; the other
  // registers land on their extremes now and then. Writing all twelve data
  // bits also checks that the narrow registers ignore the upper ones.
  function automatic reg_image_t random_settings(int p);
    reg_image_t img;
    int         i;
    for (i = 0; i < 8; i++)
      img[i] = 12'($urandom_range(0, 4095));
    case (p % 4)
      0:       img[REG_STEP_LIMIT] = 12'($urandom_range(1, 64));
      1:       img[REG_STEP_LIMIT] = 12'($urandom_range(0, 4095));
      2:       img[REG_STEP_LIMIT] = 12'($urandom_range(200, 600));
      default: img[REG_STEP_LIMIT] = 12'hFFF;
    endcase
    case (p % 3)
      0:       img[REG_MAX_VELOCITY] = 12'hFFF;
      1:       img[REG_MAX_VELOCITY] = 12'($urandom_range(0, 8));
      default: ;
    endcase
    if (p == 1)
      img[REG_SIGN_MASK] = 12'h01F;
    for (i = int'(REG_CENTER_0); i <= int'(REG_CENTER_4); i++)
      case ($urandom_range(0, 5))
        0:       img[i] = 12'h000;
        1:       img[i] = 12'h3FF;
        default: ;
      endcase
    return img;
  endfunction

  // One write per cycle through all registers. cfg_we stays high across the
  // whole sequence and drops once after the last write.
  task automatic program_registers(reg_image_t img);
    int i;
    for (i = 0; i < 8; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= cfg_reg_t'(i);
      cfg_data  <= img[i];
      @(posedge clk);
      board.set_reg(cfg_reg_t'(i), img[i]);
    end
    cfg_we <= 1'b0;
  endtask

  // Offers one request and returns at the edge that accepted it. A burst
  // keeps tvalid high from one request to the next; between bursts tvalid
  // may drop for a random gap.
  task automatic send_request(aim_set_t tgt, bit complete, bit vpres,
                              logic [VEL_IN_W-1:0] vreq);
    int gap;
    if (burst_left == 0) begin
      gap = 0;
      if ($urandom_range(0, 99) < gap_pct)
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 12) : $urandom_range(1, 3);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {vreq, tgt};
    s_tuser  <= {vpres, complete};
    do @(posedge clk); while (!s_tready);
    board.note_request(tgt, complete, vpres, vreq);
  endtask

  // Ends a phase: stop offering, wait for every outstanding result, then let
  // the pipeline run dry.
  task automatic end_phase();
    s_tvalid <= 1'b0;
    burst_left = 0;
    while (board.servo_cmd_q.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    aim_set_t aim;
    int       p;
    int       k;
    int       j;

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Default registers: slew step 61, velocity limit 200, centres 512.
    // An incomplete request before any complete one must not prime the
    // held angles; the next complete request loads its targets directly.
    send_request(aims(32767, 32767, -1, 0, 12345), 1'b0, 1'b1, 32'd5);
    send_request(aims(-32768, 32767, 0, 1, -1), 1'b1, 1'b0, 32'h7FFF_FFFF);
    // Velocity right at, just above and just below the limit.
    send_request(aims(-32768, 32767, 0, 1, -1), 1'b1, 1'b1, 32'd200);
    send_request(aims(-32768, 32767, 0, 1, -1), 1'b1, 1'b1, 32'd201);
    send_request(aims(-32768, 32767, 0, 1, -1), 1'b1, 1'b1, -32'sd201);
    // Full-scale reversal: joints 0 to 3 are limited to a 61 LSB step.
    send_request(aims(32767, -32768, 100, -100, 0), 1'b1, 1'b1, 32'h7FFF_FFFF);
    send_request(aims(-32768, 32767, 0, 1, -1), 1'b1, 1'b1, 32'h8000_0000);
    // A dropped request in the middle leaves the held angles alone.
    send_request(aims(0, 0, 32767, -32768, 5000), 1'b0, 1'b1, 32'd0);
    send_request(aims(-32768, 32767, 0, 1, -1), 1'b1, 1'b1, 32'd0);
    end_phase();

    // Widest slew and velocity limits, every joint inverted and the centres
    // at both ends. Joint 0 holds -32768 here, which inverts to +32768.
    gap_pct   <= 0;
    stall_pct <= 0;
    program_registers(settings(4095, 1023, 31, 0, 1023, 0, 1023, 1023));
    send_request(aims(-32768, 32767, 0, 1, -1), 1'b1, 1'b1, 32'd1023);
    send_request(aims(32767, -32768, -32768, 32767, 4095), 1'b1, 1'b1, 32'd1024);
    send_request(aims(32767, -32768, -32768, 32767, 4095), 1'b1, 1'b1, -32'sd1024);
    send_request(aims(-1, 1, 0, 0, -4096), 1'b1, 1'b1, -32'sd1023);
    end_phase();

    // No movement at all and a zero velocity limit; centres swapped.
    gap_pct   <= 30;
    stall_pct <= 30;
    program_registers(settings(0, 0, 0, 1023, 0, 1023, 0, 0));
    send_request(aims(32767, -32768, 32767, -32768, 32767), 1'b1, 1'b1, 32'h7FFF_FFFF);
    send_request(aims(0, 0, 0, 0, 0), 1'b1, 1'b1, 32'h8000_0000);
    send_request(aims(0, 0, 0, 0, 0), 1'b1, 1'b0, 32'd1);
    end_phase();

    // Random phases, each under its own register image and pacing. Phase 2
    // runs with no idling on either side.
    for (j = 0; j < JOINTS; j++)
      aim[j] = 16'($urandom());
    for (p = 0; p < RANDOM_PHASES; p++) begin
      gap_pct   <= (p == 2) ? 0 : $urandom_range(10, 60);
      stall_pct <= (p == 2) ? 0 : $urandom_range(10, 60);
      program_registers(random_settings(p));
      for (k = 0; k < PHASE_REQUESTS; k++) begin
        for (j = 0; j < JOINTS; j++)
          aim[j] = next_aim(aim[j]);
        send_request(aim, $urandom_range(0, 99) < 85, $urandom_range(0, 99) < 70,
                     random_velocity());
      end
      end_phase();
    end

    $display("Run covered %0d requests (%0d incomplete and dropped), %0d servo results.",
             board.accepted, board.dropped, board.results_seen);
    $display("Register images: %0d, including both limits of every register.",
             RANDOM_PHASES + 2);
    if (board.mismatches == 0 && board.servo_cmd_q.size() == 0)
      $display("PASS joint_slew_limit_servo_position_core");
    else
      $display("FAIL joint_slew_limit_servo_position_core");
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/jslsp_pkg.sv
hw/rtl/jslsp_slew_lane.sv
hw/rtl/jslsp_pos_map.sv
hw/rtl/jslsp_vel_sat.sv
hw/rtl/joint_slew_limit_servo_position_core.sv
tb/testbench.sv
